>>> hdl/twv_pkg.sv
// Package for the trapped water volume block.
// Holds the default sizes, the fixed field widths and the result record.
// No dependencies; the sequencer, the top level and the testbench import it.
package twv_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_MAX_BARS    = 1024;
    localparam int DEF_HEIGHT_BITS = 16;

    // Fixed widths of the transaction fields.
    localparam int HEIGHT_W = 16;
    localparam int VOLUME_W = 26;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic                valid;
        logic [VOLUME_W-1:0] volume;
        logic                overflow;
    } t_result;

endpackage

>>> hdl/twv_ram.sv
// Simple dual-port synchronous memory used for the bar and right-maximum stores.
// One write port and one read port; read data is registered.
// No package dependencies.
module twv_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/twv_seq.sv
// Sequencer of the trapped water volume block: bar loading, the right-maximum
// pass, the left-maximum and summing pass, and the hand-off of one result.
// Depends on twv_pkg; drives the two twv_ram instances in the top level.
module twv_seq #(
    parameter int MAX_BARS    = 1024,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    // Input transactions.
    input  logic                                             i_in_valid,
    output logic                                             o_in_ready,
    input  logic [twv_pkg::HEIGHT_W-1:0]                     i_height,
    input  logic                                             i_last_bar,
    // Bar store.
    output logic                                             o_bar_we,
    output logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] o_bar_waddr,
    output logic [((HEIGHT_BITS < twv_pkg::HEIGHT_W) ? HEIGHT_BITS
                   : twv_pkg::HEIGHT_W)-1:0]                 o_bar_wdata,
    output logic                                             o_bar_re,
    output logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] o_bar_raddr,
    input  logic [((HEIGHT_BITS < twv_pkg::HEIGHT_W) ? HEIGHT_BITS
                   : twv_pkg::HEIGHT_W)-1:0]                 i_bar_q,
    // Right-maximum store.
    output logic                                             o_rm_we,
    output logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] o_rm_waddr,
    output logic [((HEIGHT_BITS < twv_pkg::HEIGHT_W) ? HEIGHT_BITS
                   : twv_pkg::HEIGHT_W)-1:0]                 o_rm_wdata,
    output logic                                             o_rm_re,
    output logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] o_rm_raddr,
    input  logic [((HEIGHT_BITS < twv_pkg::HEIGHT_W) ? HEIGHT_BITS
                   : twv_pkg::HEIGHT_W)-1:0]                 i_rm_q,
    // Result toward the output register.
    output twv_pkg::t_result                                 o_res,
    input  logic                                             i_res_ready
);

    import twv_pkg::*;

    localparam int HW     = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
    localparam int ADDR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
    localparam int CNT_W  = $clog2(MAX_BARS + 1);

    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BARS);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MAX_BARS - 1);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_RMAX = 2'd1;
    localparam logic [1:0] S_LSUM = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ovf;
    logic                r_issue;
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_idx;
    logic [ADDR_W-1:0]   r_last;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [HW-1:0]       r_run;
    logic [VOLUME_W-1:0] r_acc;

    logic                accept;
    logic                store;
    logic [HW-1:0]       n_run;
    logic [HW-1:0]       n_lo;
    logic [HW-1:0]       n_diff;
    logic [VOLUME_W:0]   n_sum;

    // Handshake and store decision for one input transaction; no intake in reset.
    assign o_in_ready = i_rst_n && (r_state == S_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign store      = accept && (r_cnt < MAX_CNT);

    // Bar loading writes at the fill count; both passes read at the pass index.
    assign o_bar_we    = store;
    assign o_bar_waddr = r_cnt[ADDR_W-1:0];
    assign o_bar_wdata = i_height[HW-1:0];
    assign o_bar_re    = r_issue && ((r_state == S_RMAX) || (r_state == S_LSUM));
    assign o_bar_raddr = r_idx;
    assign o_rm_re     = r_issue && (r_state == S_LSUM);
    assign o_rm_raddr  = r_idx;

    // Running maximum, water level and saturating sum for the bar read last cycle.
    always_comb begin
        n_run  = (i_bar_q > r_run) ? i_bar_q : r_run;
        n_lo   = (n_run < i_rm_q) ? n_run : i_rm_q;
        n_diff = n_lo - i_bar_q;
        n_sum  = {1'b0, r_acc} + (VOLUME_W + 1)'(n_diff);
    end

    // The right-maximum pass writes the running maximum back for the sum pass.
    assign o_rm_we    = (r_state == S_RMAX) && r_rd_vld;
    assign o_rm_waddr = r_rd_addr;
    assign o_rm_wdata = n_run;

    // Result record.
    assign o_res.valid    = (r_state == S_DONE);
    assign o_res.volume   = r_acc;
    assign o_res.overflow = r_ovf;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (store) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_bar) begin
                            r_state <= S_RMAX;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_RMAX, S_LSUM: begin
                    r_rd_vld <= r_issue;
                    if (r_issue) begin
                        if (r_state == S_RMAX) begin
                            if (r_idx == '0) begin
                                r_issue <= 1'b0;
                            end
                        end else begin
                            if (r_idx == r_last) begin
                                r_issue <= 1'b0;
                            end
                        end
                    end else if (!r_rd_vld) begin
                        if (r_state == S_RMAX) begin
                            r_state <= S_LSUM;
                            r_issue <= 1'b1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_LOAD;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Pass index, running maximum and accumulator.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_idx;
        unique case (r_state)
            S_LOAD: begin
                r_run <= '0;
                if (accept && i_last_bar) begin
                    r_last <= store ? r_cnt[ADDR_W-1:0] : LAST_IDX;
                    r_idx  <= store ? r_cnt[ADDR_W-1:0] : LAST_IDX;
                end
            end
            S_RMAX: begin
                if (r_issue && (r_idx != '0)) begin
                    r_idx <= r_idx - 1'b1;
                end
                if (r_rd_vld) begin
                    r_run <= n_run;
                end
                if (!r_issue && !r_rd_vld) begin
                    r_idx <= '0;
                    r_run <= '0;
                    r_acc <= '0;
                end
            end
            S_LSUM: begin
                if (r_issue && (r_idx != r_last)) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    r_run <= n_run;
                    r_acc <= n_sum[VOLUME_W] ? {VOLUME_W{1'b1}} : n_sum[VOLUME_W-1:0];
                end
            end
            S_DONE: begin
                r_run <= '0;
            end
            default: begin
                r_run <= '0;
            end
        endcase
    end

endmodule

>>> hdl/trapped_water_volume.sv
// Trapped water volume over a histogram of bar heights.
// Input channel (i_valid / o_ready): one bar per transaction, i_height and
// i_last_bar; the bar with i_last_bar high closes the histogram.
// Output channel (o_valid / i_ready): one transaction per histogram with the
// saturated volume and an overflow flag for bars dropped past MAX_BARS.
// Bars load at one per cycle into the bar store. After the closing bar the
// block makes two passes over the n stored bars through its memories, one
// entry per cycle each: a descending pass that writes the right maxima, and
// an ascending pass that reads both stores and sums the water. The block
// takes no bars during the passes, and the memory reads are registered.
// Reset clears the fill count, the overflow flag and all handshakes; the
// stores need no clearing. A result waits in the output register while the
// receiver stalls, and loading of the next histogram goes on meanwhile; a
// second finished result waits in the sequencer until the register frees.
module trapped_water_volume #(
    parameter int MAX_BARS    = twv_pkg::DEF_MAX_BARS,
    parameter int HEIGHT_BITS = twv_pkg::DEF_HEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [twv_pkg::HEIGHT_W-1:0]  i_height,
    input  logic                          i_last_bar,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [twv_pkg::VOLUME_W-1:0]  o_volume,
    output logic                          o_overflow
);

    import twv_pkg::*;

    localparam int HW     = (HEIGHT_BITS < HEIGHT_W) ? HEIGHT_BITS : HEIGHT_W;
    localparam int ADDR_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

    logic              bar_we;
    logic [ADDR_W-1:0] bar_waddr;
    logic [HW-1:0]     bar_wdata;
    logic              bar_re;
    logic [ADDR_W-1:0] bar_raddr;
    logic [HW-1:0]     bar_q;
    logic              rm_we;
    logic [ADDR_W-1:0] rm_waddr;
    logic [HW-1:0]     rm_wdata;
    logic              rm_re;
    logic [ADDR_W-1:0] rm_raddr;
    logic [HW-1:0]     rm_q;
    t_result           w_res;
    logic              w_res_ready;

    logic                r_o_valid;
    logic [VOLUME_W-1:0] r_o_volume;
    logic                r_o_overflow;

    // Sequencer.
    twv_seq #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_height    (i_height),
        .i_last_bar  (i_last_bar),
        .o_bar_we    (bar_we),
        .o_bar_waddr (bar_waddr),
        .o_bar_wdata (bar_wdata),
        .o_bar_re    (bar_re),
        .o_bar_raddr (bar_raddr),
        .i_bar_q     (bar_q),
        .o_rm_we     (rm_we),
        .o_rm_waddr  (rm_waddr),
        .o_rm_wdata  (rm_wdata),
        .o_rm_re     (rm_re),
        .o_rm_raddr  (rm_raddr),
        .i_rm_q      (rm_q),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // Bar store.
    twv_ram #(
        .DEPTH (MAX_BARS),
        .WIDTH (HW)
    ) u_bar_ram (
        .i_clk   (i_clk),
        .i_we    (bar_we),
        .i_waddr (bar_waddr),
        .i_wdata (bar_wdata),
        .i_re    (bar_re),
        .i_raddr (bar_raddr),
        .o_rdata (bar_q)
    );

    // Right-maximum store.
    twv_ram #(
        .DEPTH (MAX_BARS),
        .WIDTH (HW)
    ) u_rm_ram (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (rm_waddr),
        .i_wdata (rm_wdata),
        .i_re    (rm_re),
        .i_raddr (rm_raddr),
        .o_rdata (rm_q)
    );

    // Output register: takes a result when empty or when its transaction completes.
    assign w_res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_res.valid && w_res_ready) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_res_ready) begin
            r_o_volume   <= w_res.volume;
            r_o_overflow <= w_res.overflow;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_volume   = r_o_volume;
    assign o_overflow = r_o_overflow;

`ifndef NO_ASSERTIONS
    // A closing bar stops intake until its result has left the sequencer.
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_bar) |=> !o_ready)
        else $error("intake still open after the closing bar");

    // The sequencer never holds a result while it takes bars.
    a_res_not_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> !o_ready)
        else $error("result pending while bars are accepted");

    // A result handed to the output register shows up on the output channel.
    a_res_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res_ready) |=> o_valid)
        else $error("result lost between sequencer and output register");
`endif

endmodule

>>> tb/testbench.sv
// Testbench for the trapped water volume block.
// It uses twv_pkg for the field widths and the default store size. It
// predicts every histogram result itself and checks the result channel.
`timescale 1ns / 1ps

module testbench;
    import twv_pkg::*;

    localparam int     MAX_BARS     = DEF_MAX_BARS;
    localparam int     HEIGHT_MAX   = (1 << HEIGHT_W) - 1;
    localparam longint VOLUME_CAP   = (longint'(1) << VOLUME_W) - 1;
    localparam int     CYCLE_LIMIT  = 400_000;
    localparam int     HOLD_CYCLES  = 2000;
    localparam int     RANDOM_ITEMS = 200;

    typedef logic [HEIGHT_W-1:0] t_height;

    typedef struct packed {
        logic [VOLUME_W-1:0] volume;
        logic                overflow;
    } t_water_result;

    // Height patterns for random histograms.
    typedef enum int {
        SHAPE_ANY,
        SHAPE_LOW,
        SHAPE_EXTREME,
        SHAPE_PLATEAU,
        SHAPE_MIXED
    } t_shape;

    // Block ports; every input is known from time zero.
    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_ready;
    t_height             i_height   = '0;
    logic                i_last_bar = 1'b0;
    logic                o_valid;
    logic                i_ready    = 1'b0;
    logic [VOLUME_W-1:0] o_volume;
    logic                o_overflow;

    // Predictor state: bars of the open histogram and its dropped-bar flag.
    t_height       loaded_bars[$];
    logic          bars_dropped = 1'b0;
    t_water_result volumes_due[$];

    // Idling controls and the long output hold.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    // Run statistics.
    int errors              = 0;
    int bars_accepted       = 0;
    int histograms_sent     = 0;
    int overflow_histograms = 0;
    int results_checked     = 0;
    int cycle_count         = 0;

    trapped_water_volume #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (DEF_HEIGHT_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_height   (i_height),
        .i_last_bar (i_last_bar),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_volume   (o_volume),
        .o_overflow (o_overflow)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out after %0d cycles, %0d results still due",
                     $time, cycle_count, volumes_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Water over the stored bars: the lower of the left and right walls
    // minus the bar itself, summed and saturated to the volume width.
    function automatic t_water_result water_volume(input t_height bars[$],
                                                   input logic dropped);
        int unsigned   right_wall[MAX_BARS];
        int unsigned   level;
        int unsigned   wall;
        longint        total;
        t_water_result res;
        level = 0;
        for (int i = bars.size() - 1; i >= 0; i--) begin
            if (bars[i] > level) level = bars[i];
            right_wall[i] = level;
        end
        level = 0;
        total = 0;
        for (int i = 0; i < bars.size(); i++) begin
            if (bars[i] > level) level = bars[i];
            wall = (level < right_wall[i]) ? level : right_wall[i];
            total += wall - bars[i];
        end
        if (total > VOLUME_CAP) total = VOLUME_CAP;
        res.volume   = total[VOLUME_W-1:0];
        res.overflow = dropped;
        return res;
    endfunction

    function automatic t_height pick_height(input t_shape shape);
        t_shape kind;
        kind = shape;
        if (kind == SHAPE_MIXED) kind = t_shape'($urandom_range(SHAPE_PLATEAU));
        case (kind)
            SHAPE_LOW:     return t_height'($urandom_range(15));
            SHAPE_EXTREME: return $urandom_range(1) ? t_height'(HEIGHT_MAX) : '0;
            SHAPE_PLATEAU: return t_height'(HEIGHT_MAX - $urandom_range(7));
            default:       return t_height'($urandom_range(HEIGHT_MAX));
        endcase
    endfunction

    // Offer one bar, wait for the transaction, then update the prediction.
    // Valid stays high on return so back-to-back bars follow without valid dropping in between.
    task automatic send_bar(input t_height height, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_height   <= height;
        i_last_bar <= last;
        do @(posedge i_clk); while (!o_ready);
        bars_accepted++;
        if (loaded_bars.size() < MAX_BARS) loaded_bars.push_back(height);
        else bars_dropped = 1'b1;
        if (last) begin
            volumes_due.push_back(water_volume(loaded_bars, bars_dropped));
            histograms_sent++;
            if (bars_dropped) overflow_histograms++;
            loaded_bars.delete();
            bars_dropped = 1'b0;
        end
    endtask

    task automatic send_shape(input t_height bars[$]);
        foreach (bars[i]) send_bar(bars[i], i == bars.size() - 1);
    endtask

    task automatic send_histogram(input int len, input t_shape shape);
        for (int i = 0; i < len; i++) send_bar(pick_height(shape), i == len - 1);
    endtask

    // Result side: check each transaction, then choose the next ready value.
    always @(posedge i_clk) begin : result_side
        t_water_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (volumes_due.size() == 0) begin
                errors++;
                $display("%0t: result with none due: volume=%0d overflow=%0b",
                         $time, o_volume, o_overflow);
            end else begin
                want = volumes_due.pop_front();
                results_checked++;
                if (o_volume !== want.volume) begin
                    errors++;
                    $display("%0t: volume mismatch: expected %0d, actual %0d",
                             $time, want.volume, o_volume);
                end
                if (o_overflow !== want.overflow) begin
                    errors++;
                    $display("%0t: overflow mismatch: expected %0b, actual %0b",
                             $time, want.overflow, o_overflow);
                end
            end
        end
        // A new hold request starts a long stretch with ready low.
        if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Single-bar histograms at the height extremes and alternating bits.
    task automatic test_single_bars();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        send_bar(t_height'(HEIGHT_MAX), 1'b1);
        send_bar('0, 1'b1);
        send_bar(16'hAAAA, 1'b1);
        send_bar(16'h5555, 1'b1);
    endtask

    // Hand-picked shapes: full-height walls, valleys, ties and slopes.
    task automatic test_shapes();
        send_shape('{t_height'(HEIGHT_MAX), 16'd0, t_height'(HEIGHT_MAX)});
        send_shape('{16'd3, 16'd0, 16'd2, 16'd0, 16'd4});
        send_shape('{16'd2, 16'd1, 16'd2, 16'd1, 16'd2});
        send_shape('{16'd9, 16'd7, 16'd3});
        send_shape('{16'd0, 16'd4, 16'd4, 16'd9});
    endtask

    // Full store: every entry written with full-height walls at both ends,
    // several dropped bars including the closing one, and a short histogram
    // afterwards to see the flag cleared.
    task automatic test_store_full();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < MAX_BARS; i++)
            send_bar((i == 0 || i == MAX_BARS - 1) ? t_height'(HEIGHT_MAX)
                     : pick_height(SHAPE_MIXED), 1'b0);
        send_bar(t_height'(HEIGHT_MAX), 1'b0);
        send_bar(16'd0, 1'b0);
        send_bar(t_height'(HEIGHT_MAX), 1'b1);
        send_shape('{16'd5, 16'd0, 16'd5});
    endtask

    // Long receiver hold while the sender keeps offering short histograms,
    // so the output register and the sequencer fill and input stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        for (int k = 0; k < 6; k++) send_histogram($urandom_range(2, 6), SHAPE_LOW);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input int items);
        int sent;
        int len;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 85) len = $urandom_range(1, 24);
            else if (pick < 98) len = $urandom_range(25, 120);
            else len = $urandom_range(200, 300);
            if (len > items - sent) len = items - sent;
            send_histogram(len, t_shape'($urandom_range(SHAPE_MIXED)));
            sent += len;
        end
    endtask

    // Random histograms across the four idling phases.
    task automatic test_random_histograms();
        run_random_phase(0, 0, RANDOM_ITEMS / 4);
        run_random_phase(67, 0, RANDOM_ITEMS / 4);
        run_random_phase(0, 67, RANDOM_ITEMS / 4);
        run_random_phase(38, 38, RANDOM_ITEMS / 4);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bars();
        test_shapes();
        test_store_full();
        test_backpressure();
        test_random_histograms();
        i_valid <= 1'b0;

        // Drain, then allow time for any stray result to show up.
        while (volumes_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d bars in %0d histograms, %0d of them past the store size.",
                 bars_accepted, histograms_sent, overflow_histograms);
        $display("Checked %0d results under sender gaps, receiver stalls and a %0d-cycle hold.",
                 results_checked, HOLD_CYCLES);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
